>>> rtl/pdb_pkg.sv
`default_nettype none

package pdb_pkg;

    localparam int GAIN_W     = 16;
    localparam int GAIN_S_W   = GAIN_W + 1;
    localparam int BAND_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_DEAD_BAND     = 3'd3,
        REG_INTEGRAL_LIM  = 3'd4,
        REG_OUTPUT_LIM    = 3'd5,
        REG_OUTPUT_MIN    = 3'd6,
        REG_DERIV_ENABLE  = 3'd7
    } cfg_index_t;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

`default_nettype wire

>>> rtl/pdb_if.sv
`default_nettype none

interface pdb_cfg_if import pdb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pdb_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] feedback;

    modport source (output valid, output command, output target, output feedback,
                    input ready);
    modport sink   (input valid, input command, input target, input feedback,
                    output ready);
endinterface

interface pdb_out_if import pdb_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DRIVE_W-1:0]    drive;
    logic signed [SAMPLE_WIDTH:0] error_used;

    modport source (output valid, output drive, output error_used, input ready);
    modport sink   (input valid, input drive, input error_used, output ready);
endinterface

`default_nettype wire

>>> rtl/pid_controller_deadband.sv
// PID controller with error dead band, integral clamp, output clamp and minimum drive.
// A request (clear or control step) is captured in an input register and its result
// lands in an output register on the next advance. One request is taken every cycle
// while the output side is ready; the rate is set by the single combinational pass from
// the input register through the gain multipliers, the integral clamp and the drive
// clamp to the result register, which also updates the integral and, in PID mode, the
// previous error for the next request. Gains are unsigned Q8.8, products are floored
// by the fraction shift, and the configuration registers are meant to be written only
// while no request is in flight.
`default_nettype none

module pid_controller_deadband import pdb_pkg::*; #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    pdb_cfg_if.sink   cfg,
    pdb_in_if.sink    sample,
    pdb_out_if.source result
);

    localparam int EW    = SAMPLE_WIDTH + 1;
    localparam int DW    = EW + 1;
    localparam int CW    = ((EW > BAND_W) ? EW : BAND_W) + 1;
    localparam int PW    = EW + GAIN_S_W;
    localparam int DPW   = DW + GAIN_S_W;
    localparam int ISW   = PW + 1;
    localparam int SUM_W = DPW + 2;

    // configuration registers
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [BAND_W-1:0]  dead_band_reg;
    logic [LIMIT_W-1:0] integral_limit_reg;
    logic [LIMIT_W-1:0] output_limit_reg;
    logic [LIMIT_W-1:0] output_minimum_reg;
    logic               deriv_enable_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            dead_band_reg      <= '0;
            integral_limit_reg <= LIMIT_RESET;
            output_limit_reg   <= LIMIT_RESET;
            output_minimum_reg <= '0;
            deriv_enable_reg   <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_GAIN_P:       gain_p_reg         <= cfg.data[GAIN_W-1:0];
                REG_GAIN_I:       gain_i_reg         <= cfg.data[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg         <= cfg.data[GAIN_W-1:0];
                REG_DEAD_BAND:    dead_band_reg      <= cfg.data[BAND_W-1:0];
                REG_INTEGRAL_LIM: integral_limit_reg <= cfg.data[LIMIT_W-1:0];
                REG_OUTPUT_LIM:   output_limit_reg   <= cfg.data[LIMIT_W-1:0];
                REG_OUTPUT_MIN:   output_minimum_reg <= cfg.data[LIMIT_W-1:0];
                REG_DERIV_ENABLE: deriv_enable_reg   <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // input register and handshake
    logic                           s1_valid_reg;
    logic                           s1_cmd_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_target_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_feedback_reg;
    logic                           out_valid_reg;
    logic signed [DRIVE_W-1:0]      drive_reg;
    logic signed [EW-1:0]           error_used_reg;
    logic signed [DRIVE_W-1:0]      integral_reg;
    logic signed [EW-1:0]           prev_err_reg;
    logic                           advance;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_cmd_reg      <= sample.command;
            s1_target_reg   <= sample.target;
            s1_feedback_reg <= sample.feedback;
        end
    end

    // error and dead band
    logic signed [EW-1:0]    err;
    logic signed [CW-1:0]    err_c;
    logic signed [CW-1:0]    band_c;
    logic signed [EW-1:0]    err_db;
    logic signed [DW-1:0]    err_diff;
    logic signed [GAIN_S_W-1:0] gp_s;
    logic signed [GAIN_S_W-1:0] gi_s;
    logic signed [GAIN_S_W-1:0] gd_s;
    logic signed [PW-1:0]    prod_p;
    logic signed [PW-1:0]    prod_i;
    logic signed [DPW-1:0]   prod_d;
    logic signed [PW-1:0]    term_p;
    logic signed [PW-1:0]    term_i;
    logic signed [DPW-1:0]   term_d;
    logic signed [ISW-1:0]   int_sum;
    logic signed [ISW-1:0]   int_lim;
    logic signed [ISW-1:0]   int_clamped;
    logic signed [DRIVE_W-1:0] integral_new;
    logic signed [SUM_W-1:0] drive_sum;
    logic signed [SUM_W-1:0] out_lim;
    logic signed [SUM_W-1:0] drive_clamped;
    logic signed [DRIVE_W-1:0] drive_c;
    logic signed [DRIVE_W-1:0] omin_s;
    logic signed [DRIVE_W-1:0] drive_final;

    assign err    = EW'(s1_target_reg) - EW'(s1_feedback_reg);
    assign err_c  = CW'(err);
    assign band_c = CW'(signed'({1'b0, dead_band_reg}));
    assign err_db = ((err_c > -band_c) && (err_c < band_c)) ? '0 : err;

    assign err_diff = DW'(err_db) - DW'(prev_err_reg);

    assign gp_s = signed'({1'b0, gain_p_reg});
    assign gi_s = signed'({1'b0, gain_i_reg});
    assign gd_s = signed'({1'b0, gain_d_reg});

    assign prod_p = gp_s * err_db;
    assign prod_i = gi_s * err_db;
    assign prod_d = gd_s * err_diff;

    // arithmetic shift floors toward minus infinity
    assign term_p = prod_p >>> GAIN_FRAC_BITS;
    assign term_i = prod_i >>> GAIN_FRAC_BITS;
    assign term_d = prod_d >>> GAIN_FRAC_BITS;

    assign int_sum = ISW'(term_i) + ISW'(integral_reg);
    assign int_lim = ISW'(signed'({1'b0, integral_limit_reg}));

    always_comb
    begin
        if (int_sum > int_lim)
            int_clamped = int_lim;
        else if (int_sum < -int_lim)
            int_clamped = -int_lim;
        else
            int_clamped = int_sum;
    end

    assign integral_new = int_clamped[DRIVE_W-1:0];

    assign drive_sum = SUM_W'(term_p) + SUM_W'(integral_new)
                     + (deriv_enable_reg ? SUM_W'(term_d) : SUM_W'(0));
    assign out_lim   = SUM_W'(signed'({1'b0, output_limit_reg}));

    always_comb
    begin
        if (drive_sum > out_lim)
            drive_clamped = out_lim;
        else if (drive_sum < -out_lim)
            drive_clamped = -out_lim;
        else
            drive_clamped = drive_sum;
    end

    assign drive_c = drive_clamped[DRIVE_W-1:0];
    assign omin_s  = signed'({1'b0, output_minimum_reg});

    // minimum applies after the clamp and may exceed the limit
    always_comb
    begin
        if ((drive_c > 0) && (drive_c < omin_s))
            drive_final = omin_s;
        else if ((drive_c < 0) && (drive_c > -omin_s))
            drive_final = -omin_s;
        else
            drive_final = drive_c;
    end

    // result register and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            if (s1_cmd_reg == CMD_CLEAR)
            begin
                integral_reg <= '0;
                prev_err_reg <= '0;
            end
            else
            begin
                integral_reg <= integral_new;
                if (deriv_enable_reg)
                    prev_err_reg <= err_db;
            end
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s1_cmd_reg == CMD_CLEAR)
            begin
                drive_reg      <= '0;
                error_used_reg <= '0;
            end
            else
            begin
                drive_reg      <= drive_final;
                error_used_reg <= err_db;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.drive      = drive_reg;
    assign result.error_used = error_used_reg;

    // a clear leaves a zero result and zero state behind
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_cmd_reg == CMD_CLEAR)
        |=> (drive_reg == '0) && (error_used_reg == '0)
            && (integral_reg == '0) && (prev_err_reg == '0))
        else $error("clear did not zero result and state");

    // PI mode step keeps the previous error
    a_pi_keeps_prev: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_cmd_reg == CMD_STEP) && !deriv_enable_reg
        |=> $stable(prev_err_reg))
        else $error("previous error changed in PI mode");

    // the input register never advances into a held result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb import pdb_pkg::*;;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_SHIFT = 8;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]  drive;
        logic signed [SAMPLE_W:0]   error_used;
    } result_t;

    typedef struct packed {
        bit      typed;
        result_t value;
    } req_note_t;

    typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        cfg_index_t                 idx;
        logic [CFG_DATA_W-1:0]      value;
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] tgt;
        logic signed [SAMPLE_W-1:0] fb;
        bit                         typed;
        result_t                    want;
    } row_t;

    localparam result_t ZERO_RESULT = '0;

    logic clk;
    logic rst_n;

    pdb_cfg_if                          cfg_bus();
    pdb_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) sample_bus();
    pdb_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) result_bus();

    pid_controller_deadband #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .GAIN_FRAC_BITS (GAIN_SHIFT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    // controller model: settings and state
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [BAND_W-1:0]  band;
    logic [LIMIT_W-1:0] int_lim;
    logic [LIMIT_W-1:0] out_lim;
    logic [LIMIT_W-1:0] out_min;
    logic               deriv_on;
    longint             acc_integral;
    longint             last_error;

    result_t   pending_results[$];
    req_note_t req_notes[$];
    row_t      plan[$];

    int mismatch_count;
    bit send_idle;
    bit recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic result_t predict_step(input logic cmd,
                                             input logic signed [SAMPLE_W-1:0] tgt,
                                             input logic signed [SAMPLE_W-1:0] fb);
        result_t r;
        longint  e;
        longint  d;
        if (cmd == CMD_CLEAR)
        begin
            acc_integral = 0;
            last_error   = 0;
            return ZERO_RESULT;
        end
        e = longint'(tgt) - longint'(fb);
        if (e > -longint'(band) && e < longint'(band))
            e = 0;
        acc_integral = clamp_sym(acc_integral + ((longint'(ki) * e) >>> GAIN_SHIFT),
                                 longint'(int_lim));
        d = ((longint'(kp) * e) >>> GAIN_SHIFT) + acc_integral;
        if (deriv_on)
            d += (longint'(kd) * (e - last_error)) >>> GAIN_SHIFT;
        d = clamp_sym(d, longint'(out_lim));
        // minimum applies after the clamp, so it may exceed the limit
        if (d > 0 && d < longint'(out_min))
            d = longint'(out_min);
        else if (d < 0 && d > -longint'(out_min))
            d = -longint'(out_min);
        if (deriv_on)
            last_error = e;
        r.drive      = d[DRIVE_W-1:0];
        r.error_used = e[SAMPLE_W:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        result_t   got;
        result_t   want;
        result_t   calc;
        req_note_t note;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.drive      = result_bus.drive;
                got.error_used = result_bus.error_used;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with none pending: drive %0d error %0d",
                                              got.drive, got.error_used));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.drive !== want.drive)
                        report_mismatch($sformatf("drive %0d, want %0d",
                                                  got.drive, want.drive));
                    if (got.error_used !== want.error_used)
                        report_mismatch($sformatf("error_used %0d, want %0d",
                                                  got.error_used, want.error_used));
                end
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                calc = predict_step(sample_bus.command, sample_bus.target,
                                    sample_bus.feedback);
                if (req_notes.size() != 0)
                begin
                    note = req_notes.pop_front();
                    if (note.typed)
                        calc = note.value;
                end
                pending_results.push_back(calc);
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_index_t'(cfg_bus.index))
                    REG_GAIN_P:       kp       = cfg_bus.data;
                    REG_GAIN_I:       ki       = cfg_bus.data;
                    REG_GAIN_D:       kd       = cfg_bus.data;
                    REG_DEAD_BAND:    band     = cfg_bus.data;
                    REG_INTEGRAL_LIM: int_lim  = cfg_bus.data[LIMIT_W-1:0];
                    REG_OUTPUT_LIM:   out_lim  = cfg_bus.data[LIMIT_W-1:0];
                    REG_OUTPUT_MIN:   out_min  = cfg_bus.data[LIMIT_W-1:0];
                    REG_DERIV_ENABLE: deriv_on = cfg_bus.data[0];
                    default: ;
                endcase
            end
        end
    end

    // result side: random stall (possibly none) ahead of each result while recv_idle is set
    initial
    begin : result_sink
        int stall;
        result_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 6) : 0;
            if (stall != 0)
            begin
                @(negedge clk) result_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    task automatic send_request(input logic cmd,
                                input logic signed [SAMPLE_W-1:0] tgt,
                                input logic signed [SAMPLE_W-1:0] fb,
                                input bit typed, input result_t value);
        int        gap;
        req_note_t note;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        note.typed = typed;
        note.value = value;
        req_notes.push_back(note);
        sample_bus.valid    <= 1'b1;
        sample_bus.command  <= cmd;
        sample_bus.target   <= tgt;
        sample_bus.feedback <= fb;
        do @(posedge clk); while (!sample_bus.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // stop sending and wait until every request has its result, reporting any that never arrive
    task automatic settle();
        int waited;
        sample_bus.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
    endtask

    function automatic void add_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        row_t row;
        row       = '0;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    function automatic void add_req(input logic cmd, input int tgt, input int fb,
                                    input bit typed = 1'b0, input int drv = 0,
                                    input int err = 0);
        row_t row;
        row                 = '0;
        row.kind            = ROW_REQ;
        row.cmd             = cmd;
        row.tgt             = tgt[SAMPLE_W-1:0];
        row.fb              = fb[SAMPLE_W-1:0];
        row.typed           = typed;
        row.want.drive      = drv[DRIVE_W-1:0];
        row.want.error_used = err[SAMPLE_W:0];
        plan.push_back(row);
    endfunction

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0]      v;
        logic signed [SAMPLE_W-1:0] t;
        logic signed [SAMPLE_W-1:0] f;
        logic                       cmd;
        int                         sel;
        int                         tmp;

        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_GAIN_P;
        cfg_bus.data        = '0;
        sample_bus.valid    = 1'b0;
        sample_bus.command  = CMD_STEP;
        sample_bus.target   = '0;
        sample_bus.feedback = '0;
        kp                  = '0;
        ki                  = '0;
        kd                  = '0;
        band                = '0;
        int_lim             = LIMIT_RESET;
        out_lim             = LIMIT_RESET;
        out_min             = '0;
        deriv_on            = 1'b1;
        acc_integral        = 0;
        last_error          = 0;
        mismatch_count      = 0;
        send_idle           = 1'b1;
        recv_idle           = 1'b1;

        // zero gains after reset: drive stays 0, error passes through
        add_req(CMD_STEP, 0, 0, 1'b1, 0, 0);
        add_req(CMD_STEP, 32767, -32768, 1'b1, 0, 65535);
        add_req(CMD_STEP, -32768, 32767, 1'b1, 0, -65535);
        add_req(CMD_CLEAR, 0, 0, 1'b1, 0, 0);
        add_req(CMD_STEP, 1234, 1000, 1'b1, 0, 234);
        add_reg(REG_GAIN_P, 16'h0100);
        add_reg(REG_GAIN_I, 16'h0040);
        add_reg(REG_GAIN_D, 16'h0080);
        add_reg(REG_INTEGRAL_LIM, 16'd1000);
        add_reg(REG_OUTPUT_LIM, 16'd2000);
        add_req(CMD_STEP, 100, 0);
        add_req(CMD_STEP, 32767, -32768);
        add_req(CMD_STEP, -32768, 32767);
        add_req(CMD_STEP, -5, 0);
        add_req(CMD_CLEAR, 77, -77, 1'b1, 0, 0);
        // dead band edges
        add_reg(REG_DEAD_BAND, 16'd50);
        add_req(CMD_STEP, 49, 0);
        add_req(CMD_STEP, 50, 0);
        add_req(CMD_STEP, -49, 0);
        add_req(CMD_STEP, -50, 0);
        // minimum above the output limit
        add_reg(REG_OUTPUT_MIN, 16'd3000);
        add_req(CMD_STEP, 60, 0);
        add_req(CMD_STEP, -60, 0);
        // zero drive is not raised
        add_req(CMD_CLEAR, 0, 0, 1'b1, 0, 0);
        add_req(CMD_STEP, 10, 10);
        // pi mode
        add_reg(REG_DERIV_ENABLE, 16'd0);
        add_req(CMD_STEP, 300, 0);
        add_req(CMD_STEP, -300, 0);
        // largest gains, widest limits
        add_reg(REG_GAIN_P, 16'hFFFF);
        add_reg(REG_GAIN_I, 16'hFFFF);
        add_reg(REG_GAIN_D, 16'hFFFF);
        add_reg(REG_DEAD_BAND, 16'd0);
        add_reg(REG_INTEGRAL_LIM, 16'hFFFF);
        add_reg(REG_OUTPUT_LIM, 16'hFFFF);
        add_reg(REG_OUTPUT_MIN, 16'd0);
        add_reg(REG_DERIV_ENABLE, 16'hFFFF);
        add_req(CMD_STEP, 32767, -32768);
        add_req(CMD_STEP, -32768, 32767);
        add_req(CMD_CLEAR, -1, -1, 1'b1, 0, 0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[n].idx, plan[n].value);
            end
            else
                send_request(plan[n].cmd, plan[n].tgt, plan[n].fb, plan[n].typed,
                             plan[n].want);
        end

        for (int p = 0; p < 10; p++)
        begin
            settle();
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            for (int r = 0; r < 8; r++)
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = '1;
                    2, 3:    v = CFG_DATA_W'($urandom_range(0, 16'h01FF));
                    default: v = CFG_DATA_W'($urandom);
                endcase
                write_reg(cfg_index_t'(r), v);
            end
            for (int n = 0; n < 64; n++)
            begin
                sel = $urandom_range(0, 19);
                cmd = (sel == 0) ? CMD_CLEAR : CMD_STEP;
                f   = SAMPLE_W'($urandom);
                t   = SAMPLE_W'($urandom);
                if (sel >= 8)
                begin
                    // target near feedback keeps the error small
                    tmp = int'(f) + int'($urandom_range(0, 600)) - 300;
                    if (tmp > 32767)
                        tmp = 32767;
                    if (tmp < -32768)
                        tmp = -32768;
                    t = tmp[SAMPLE_W-1:0];
                end
                send_request(cmd, t, f, 1'b0, ZERO_RESULT);
            end
        end

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
